// ----- sv/lisa_pkg.sv -----
// Package for the lowest-index server allocator.
// Field widths, reset values and the result struct used by lisa_scan, the top level and the testbench.
// No dependencies.
`timescale 1ns / 1ps

package lisa_pkg;

    localparam int MAX_SERVERS_DEF = 128;

    localparam int CFG_W  = 8;
    localparam int TIME_W = 32;
    localparam int WANT_W = 8;
    localparam int DUR_W  = 16;
    localparam int BUSY_W = 33;
    localparam int SUM_W  = 14;

    localparam logic [CFG_W-1:0]  CFG_RESET  = 8'd128;
    localparam logic [BUSY_W-1:0] BUSY_RESET = 33'd1;

    typedef struct packed {
        logic             granted;
        logic [SUM_W-1:0] index_sum;
    } t_result;

endpackage

// ----- sv/lisa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lisa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lisa_scan.sv -----
// Allocation sequencer: clearing pass, count/sum pass and commit pass over the
// busy-until RAM. Depends on lisa_pkg and lisa_ram.
`timescale 1ns / 1ps

module lisa_scan #(
    parameter int MAX_SERVERS = lisa_pkg::MAX_SERVERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lisa_pkg::TIME_W-1:0] i_request_time,
    input  logic [lisa_pkg::WANT_W-1:0] i_servers_wanted,
    input  logic [lisa_pkg::DUR_W-1:0]  i_busy_duration,
    input  logic [lisa_pkg::CFG_W-1:0]  i_server_count,
    output logic                        o_res_valid,
    output lisa_pkg::t_result           o_res,
    input  logic                        i_res_take
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int N_W   = ($clog2(MAX_SERVERS + 1) > lisa_pkg::CFG_W)
                           ? $clog2(MAX_SERVERS + 1) : lisa_pkg::CFG_W;
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_SERVERS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [N_W-1:0]                r_addr, n_addr;
    logic                          r_dv, n_dv;
    logic [IDX_W-1:0]              r_didx, n_didx;
    logic [IDX_W-1:0]              r_last, n_last;
    logic [N_W-1:0]                r_n, n_n;
    logic [lisa_pkg::WANT_W-1:0]   r_wanted, n_wanted;
    logic [lisa_pkg::WANT_W-1:0]   r_found, n_found;
    logic [lisa_pkg::TIME_W-1:0]   r_now, n_now;
    logic [lisa_pkg::DUR_W-1:0]    r_dur, n_dur;
    lisa_pkg::t_result             r_res, n_res;

    logic                          ram_we, ram_re;
    logic [IDX_W-1:0]              ram_waddr;
    logic [lisa_pkg::BUSY_W-1:0]   ram_wdata, ram_rdata;
    logic                          entry_free;
    logic [N_W-1:0]                cfg_n;
    logic [lisa_pkg::WANT_W-1:0]   found_inc;

    lisa_ram #(
        .WIDTH (lisa_pkg::BUSY_W),
        .DEPTH (MAX_SERVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign entry_free = (ram_rdata <= {1'b0, r_now});
    assign found_inc  = r_found + lisa_pkg::WANT_W'(1);
    assign cfg_n      = (N_W'(i_server_count) > N_MAX) ? N_MAX : N_W'(i_server_count);
    assign o_stall    = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res      = r_res;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_dv     = 1'b0;
        n_didx   = r_didx;
        n_last   = r_last;
        n_n      = r_n;
        n_wanted = r_wanted;
        n_found  = r_found;
        n_now    = r_now;
        n_dur    = r_dur;
        n_res    = r_res;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_addr[IDX_W-1:0];
        ram_wdata = lisa_pkg::BUSY_RESET;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + N_W'(1);
                if (r_addr == N_MAX - N_W'(1)) begin
                    n_state = ST_IDLE;
                    n_addr  = '0;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_now    = i_request_time;
                    n_dur    = i_busy_duration;
                    n_wanted = i_servers_wanted;
                    n_n      = cfg_n;
                    n_found  = '0;
                    n_addr   = '0;
                    n_res    = '{granted: 1'b0, index_sum: '0};
                    if (i_servers_wanted == '0) begin
                        n_res.granted = 1'b1;
                        n_state       = ST_DONE;
                    end else if (cfg_n == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_addr < r_n) begin
                    ram_re = 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_addr[IDX_W-1:0];
                    n_addr = r_addr + N_W'(1);
                end
                if (r_dv) begin
                    if (entry_free) begin
                        n_found = found_inc;
                        n_res.index_sum = r_res.index_sum
                                          + lisa_pkg::SUM_W'(r_didx)
                                          + lisa_pkg::SUM_W'(1);
                    end
                    if (entry_free && (found_inc == r_wanted)) begin
                        n_last  = r_didx;
                        n_state = ST_COMMIT;
                        n_addr  = '0;
                        n_dv    = 1'b0;
                    end else if ((N_W'(r_didx) + N_W'(1)) == r_n) begin
                        n_res   = '{granted: 1'b0, index_sum: '0};
                        n_state = ST_DONE;
                        n_dv    = 1'b0;
                    end
                end
            end
            ST_COMMIT: begin
                if (r_addr <= N_W'(r_last)) begin
                    ram_re = 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_addr[IDX_W-1:0];
                    n_addr = r_addr + N_W'(1);
                end
                if (r_dv) begin
                    ram_waddr = r_didx;
                    ram_wdata = {1'b0, r_now} + lisa_pkg::BUSY_W'(r_dur);
                    ram_we    = entry_free;
                    if (r_didx == r_last) begin
                        n_res.granted = 1'b1;
                        n_state       = ST_DONE;
                        n_dv          = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dv    <= n_dv;
        end
        r_didx   <= n_didx;
        r_last   <= n_last;
        r_n      <= n_n;
        r_wanted <= n_wanted;
        r_found  <= n_found;
        r_now    <= n_now;
        r_dur    <= n_dur;
        r_res    <= n_res;
    end

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_COMMIT))
        else $error("RAM write outside clear or commit pass");

    a_scan_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_found < r_wanted))
        else $error("scan continued after enough servers found");

    a_commit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == ST_COMMIT) |-> (ram_waddr <= r_last))
        else $error("commit wrote past the last selected server");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_SCAN || r_state == ST_DONE))
        else $error("accepted transaction did not start work");

endmodule

// ----- sv/lowest_index_server_allocator.sv -----
// Top level of the lowest-index server allocator.
// Holds the server_count register and the result register; depends on
// lisa_pkg and lisa_scan.
`timescale 1ns / 1ps

// One request transaction is worked at a time through the single read port of
// the busy-until RAM. After reset a clearing pass writes every entry, during
// which requests stall. A request is then scanned from server 0 up to the last
// server examined and, on success, committed over the servers up to the last
// server taken, passing through the idle and done states. A failed request
// skips the commit pass. A request for zero servers, or with server_count of
// zero, goes from idle straight to done. The result sits in an output
// register, so the next request is taken while the previous result waits.
module lowest_index_server_allocator #(
    parameter int MAX_SERVERS = lisa_pkg::MAX_SERVERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lisa_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lisa_pkg::TIME_W-1:0] i_request_time,
    input  logic [lisa_pkg::WANT_W-1:0] i_servers_wanted,
    input  logic [lisa_pkg::DUR_W-1:0]  i_busy_duration,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_granted,
    output logic [lisa_pkg::SUM_W-1:0]  o_index_sum
);

    logic [lisa_pkg::CFG_W-1:0] r_server_count;
    logic                       r_out_valid;
    lisa_pkg::t_result          r_out;
    logic                       res_valid;
    lisa_pkg::t_result          res;
    logic                       res_take;

    lisa_scan #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_request_time   (i_request_time),
        .i_servers_wanted (i_servers_wanted),
        .i_busy_duration  (i_busy_duration),
        .i_server_count   (r_server_count),
        .o_res_valid      (res_valid),
        .o_res            (res),
        .i_res_take       (res_take)
    );

    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= lisa_pkg::CFG_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_server_count <= i_cfg_data;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_granted   = r_out.granted;
    assign o_index_sum = r_out.index_sum;

endmodule

// ----- dv/tb_lowest_index_server_allocator.sv -----
// Self-checking testbench for lowest_index_server_allocator.
// Directed table then randomized requests, scored against a busy-until predictor.
// Depends on lisa_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module tb_lowest_index_server_allocator;

    localparam int SERVERS       = lisa_pkg::MAX_SERVERS_DEF;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 165;
    localparam int PAUSE_AT      = 70;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [lisa_pkg::TIME_W-1:0] req_time;
        logic [lisa_pkg::WANT_W-1:0] wanted;
        logic [lisa_pkg::DUR_W-1:0]  duration;
        logic [lisa_pkg::CFG_W-1:0]  count;
        logic                        typed;
        logic                        granted;
        logic [lisa_pkg::SUM_W-1:0]  index_sum;
    } t_directed_row;

    localparam int NUM_DIRECTED = 23;
    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{ROW_REQ, 32'd0,          8'd1,   16'd5,      8'd0,   1'b1, 1'b0, 14'd0},
        '{ROW_REQ, 32'd0,          8'd0,   16'd0,      8'd0,   1'b1, 1'b1, 14'd0},
        '{ROW_REQ, 32'd1,          8'd1,   16'd0,      8'd0,   1'b1, 1'b1, 14'd1},
        '{ROW_REQ, 32'd1,          8'd128, 16'd10,     8'd0,   1'b1, 1'b1, 14'd8256},
        '{ROW_REQ, 32'd10,         8'd1,   16'd0,      8'd0,   1'b1, 1'b0, 14'd0},
        '{ROW_REQ, 32'd11,         8'd255, 16'd0,      8'd0,   1'b1, 1'b0, 14'd0},
        '{ROW_REQ, 32'd11,         8'd3,   16'd65535,  8'd0,   1'b1, 1'b1, 14'd6},
        '{ROW_REQ, 32'd11,         8'd2,   16'd0,      8'd0,   1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'hFFFF_FFFF,  8'd0,   16'hFFFF,   8'd0,   1'b1, 1'b1, 14'd0},
        '{ROW_REQ, 32'hFFFF_FFFF,  8'd200, 16'hFFFF,   8'd0,   1'b1, 1'b0, 14'd0},
        '{ROW_REQ, 32'd12,         8'd125, 16'd7,      8'd0,   1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'd12,         8'd1,   16'd0,      8'd0,   1'b0, 1'b0, 14'd0},
        '{ROW_CFG, 32'd0,          8'd0,   16'd0,      8'd0,   1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'd100,        8'd0,   16'd0,      8'd0,   1'b1, 1'b1, 14'd0},
        '{ROW_REQ, 32'd100,        8'd1,   16'd0,      8'd0,   1'b1, 1'b0, 14'd0},
        '{ROW_CFG, 32'd0,          8'd0,   16'd0,      8'd255, 1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'd65546,      8'd128, 16'd0,      8'd0,   1'b0, 1'b0, 14'd0},
        '{ROW_CFG, 32'd0,          8'd0,   16'd0,      8'd1,   1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'd65546,      8'd2,   16'd0,      8'd0,   1'b1, 1'b0, 14'd0},
        '{ROW_REQ, 32'd65546,      8'd1,   16'd3,      8'd0,   1'b1, 1'b1, 14'd1},
        '{ROW_CFG, 32'd0,          8'd0,   16'd0,      8'd128, 1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'd65547,      8'd127, 16'd0,      8'd0,   1'b0, 1'b0, 14'd0},
        '{ROW_REQ, 32'd65547,      8'd1,   16'd0,      8'd0,   1'b0, 1'b0, 14'd0}
    };

    localparam logic [lisa_pkg::CFG_W-1:0] PHASE_COUNT [NUM_PHASES] = '{
        8'd128, 8'd1, 8'd0, 8'd255, 8'd64, 8'd0, 8'd128
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [lisa_pkg::CFG_W-1:0]  i_cfg_data = '0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [lisa_pkg::TIME_W-1:0] i_request_time = '0;
    logic [lisa_pkg::WANT_W-1:0] i_servers_wanted = '0;
    logic [lisa_pkg::DUR_W-1:0]  i_busy_duration = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b1;
    logic                        o_granted;
    logic [lisa_pkg::SUM_W-1:0]  o_index_sum;

    logic [lisa_pkg::BUSY_W-1:0] free_at [SERVERS];
    logic [lisa_pkg::CFG_W-1:0]  count_reg;
    logic [lisa_pkg::TIME_W-1:0] base_time;
    lisa_pkg::t_result           pending_grants [$];
    int                          error_count = 0;
    bit                          tx_no_gap = 1'b0;
    bit                          rx_no_stall = 1'b0;

    lowest_index_server_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_request_time   (i_request_time),
        .i_servers_wanted (i_servers_wanted),
        .i_busy_duration  (i_busy_duration),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_granted        (o_granted),
        .o_index_sum      (o_index_sum)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned usable_servers();
        return (count_reg > SERVERS) ? SERVERS : count_reg;
    endfunction

    // All-or-nothing: count the lowest free servers, commit them only if enough.
    function automatic lisa_pkg::t_result allocate_servers(
        input logic [lisa_pkg::TIME_W-1:0] t,
        input logic [lisa_pkg::WANT_W-1:0] k,
        input logic [lisa_pkg::DUR_W-1:0]  d);
        int unsigned       usable;
        int unsigned       found;
        int unsigned       sum;
        int unsigned       i;
        lisa_pkg::t_result r;
        usable = usable_servers();
        found  = 0;
        sum    = 0;
        for (i = 0; i < usable && found < k; i++) begin
            if (free_at[i] <= {1'b0, t}) begin
                found++;
                sum += i + 1;
            end
        end
        r = '0;
        if (found < k) begin
            return r;
        end
        found = 0;
        for (i = 0; i < usable && found < k; i++) begin
            if (free_at[i] <= {1'b0, t}) begin
                free_at[i] = {1'b0, t} + lisa_pkg::BUSY_W'(d);
                found++;
            end
        end
        r.granted   = 1'b1;
        r.index_sum = lisa_pkg::SUM_W'(sum);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        if (error_count < MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
        error_count++;
    endtask

    task automatic wait_drained();
        while (pending_grants.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_server_count(input logic [lisa_pkg::CFG_W-1:0] value);
        i_valid = 1'b0;
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        count_reg = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_request(input logic [lisa_pkg::TIME_W-1:0] t,
                                input logic [lisa_pkg::WANT_W-1:0] k,
                                input logic [lisa_pkg::DUR_W-1:0] d, input bit typed,
                                input lisa_pkg::t_result typed_result);
        int                gap;
        lisa_pkg::t_result predicted;
        gap = tx_no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_request_time   = t;
        i_servers_wanted = k;
        i_busy_duration  = d;
        do @(posedge i_clk); while (o_stall);
        predicted = allocate_servers(t, k, d);
        if (typed) begin
            predicted = typed_result;
        end
        pending_grants = {pending_grants, predicted};
        @(negedge i_clk);
    endtask

    // Mostly in-order requests near the running time; the rest are zero-server
    // requests and impossible counts at random times, and late arrivals.
    task automatic send_random_request();
        int unsigned                 usable;
        int unsigned                 pick;
        int unsigned                 cap;
        logic [lisa_pkg::TIME_W-1:0] t;
        logic [lisa_pkg::WANT_W-1:0] k;
        logic [lisa_pkg::DUR_W-1:0]  d;
        usable    = usable_servers();
        pick      = $urandom_range(0, 99);
        base_time = base_time + $urandom_range(0, 6);
        if (pick < 8) begin
            t = $urandom;
            k = '0;
            d = lisa_pkg::DUR_W'($urandom);
        end else if (pick < 16) begin
            t = $urandom;
            k = lisa_pkg::WANT_W'($urandom_range(usable + 1, 255));
            d = lisa_pkg::DUR_W'($urandom);
        end else begin
            t   = (pick < 22) ? base_time - $urandom_range(0, 40) : base_time;
            cap = (usable < 8) ? usable : 8;
            k   = ($urandom_range(0, 3) == 0) ? lisa_pkg::WANT_W'($urandom_range(0, usable))
                                              : lisa_pkg::WANT_W'($urandom_range(0, cap));
            d   = (usable >= 16 && $urandom_range(0, 49) == 0)
                  ? lisa_pkg::DUR_W'($urandom_range(0, 65535))
                  : lisa_pkg::DUR_W'($urandom_range(0, 24));
        end
        send_request(t, k, d, 1'b0, '0);
    endtask

    initial begin : stimulus
        lisa_pkg::t_result          typed_result;
        int                         phase;
        int                         n;
        int                         items;
        logic [lisa_pkg::CFG_W-1:0] count;
        for (n = 0; n < SERVERS; n++) begin
            free_at[n] = lisa_pkg::BUSY_RESET;
        end
        count_reg = lisa_pkg::CFG_RESET;
        base_time = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_server_count(DIRECTED[r].count);
            end else begin
                typed_result.granted   = DIRECTED[r].granted;
                typed_result.index_sum = DIRECTED[r].index_sum;
                send_request(DIRECTED[r].req_time, DIRECTED[r].wanted, DIRECTED[r].duration,
                             DIRECTED[r].typed, typed_result);
            end
        end

        base_time = 32'd70000;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            count = (phase == 4) ? lisa_pkg::CFG_W'($urandom_range(2, 127))
                                 : PHASE_COUNT[phase];
            write_server_count(count);
            if (phase == NUM_PHASES - 1) begin
                base_time = 32'hFFFF_0000;
            end
            items = (count == 0) ? 30 : PHASE_ITEMS;
            for (n = 0; n < items; n++) begin
                if (n % 32 == 0) begin
                    tx_no_gap   = ($urandom_range(0, 3) == 0);
                    rx_no_stall = ($urandom_range(0, 3) == 0);
                end
                if (n == PAUSE_AT) begin
                    i_valid = 1'b0;
                    wait_drained();
                end
                send_random_request();
            end
        end

        i_valid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_grants.size() == 0) begin
            $display("lowest_index_server_allocator regression: pass");
        end else begin
            $display("lowest_index_server_allocator regression: fail");
        end
        $finish;
    end

    initial begin : result_sink
        int                hold;
        lisa_pkg::t_result expected;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = rx_no_stall ? 0 : $urandom_range(0, 12);
            if (hold > 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected transaction, granted", 0, o_granted);
            end else begin
                expected = pending_grants.pop_front();
                if (o_granted !== expected.granted) begin
                    report_mismatch("granted", expected.granted, o_granted);
                end
                if (o_index_sum !== expected.index_sum) begin
                    report_mismatch("index_sum", expected.index_sum, o_index_sum);
                end
            end
            @(negedge i_clk);
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("lowest_index_server_allocator regression: fail");
        $finish;
    end

endmodule

// ----- lowest_index_server_allocator.f -----
sv/lisa_pkg.sv
sv/lisa_ram.sv
sv/lisa_scan.sv
sv/lowest_index_server_allocator.sv
dv/tb_lowest_index_server_allocator.sv
